// ----- design/gbp_pkg.sv -----
// Shared constants, types and helper functions for the gshare branch predictor.
`timescale 1ns / 1ps

package gbp_pkg;

   localparam int HIST_BITS   = 12;                 // maximum number of history/index bits
   localparam int TABLE_DEPTH = 1 << HIST_BITS;
   localparam int CTR_W       = 2;
   localparam int ADDR_W      = 32;
   localparam int COUNT_W     = 32;
   localparam int K_W         = 4;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 4;

   localparam logic [K_W-1:0] K_RESET    = 4'd5;
   localparam logic           HASH_RESET = 1'b1;

   localparam logic [CTR_W-1:0] CTR_STRONG_NT = 2'd0;
   localparam logic [CTR_W-1:0] CTR_WEAK_NT   = 2'd1;
   localparam logic [CTR_W-1:0] CTR_WEAK_T    = 2'd2;
   localparam logic [CTR_W-1:0] CTR_STRONG_T  = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HISTORY_BITS = 4'd0,
      CSR_HASH_ADDRESS = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic                 en;
      logic [HIST_BITS-1:0] addr;
      logic [CTR_W-1:0]     data;
   } tbl_write_type;

   typedef struct packed {
      logic s1_valid;
      logic s1_ready;
   } stage_status_type;

   // Index mask of k low bits, k clamped to the table index width (HIST_BITS).
   function automatic logic [HIST_BITS-1:0] index_mask(input logic [K_W-1:0] k);
      logic [HIST_BITS-1:0] m;
      int                   lim;
      lim = (int'(k) > HIST_BITS) ? HIST_BITS : int'(k);
      for (int i = 0; i < HIST_BITS; i++) begin
         m[i] = (i < lim);
      end
      return m;
   endfunction

   // Two-bit counter training; weak states jump to the strong state of the outcome.
   function automatic logic [CTR_W-1:0] train(input logic [CTR_W-1:0] ctr, input logic went);
      logic [CTR_W-1:0] n;
      case (ctr)
         CTR_STRONG_NT: n = went ? CTR_WEAK_NT  : CTR_STRONG_NT;
         CTR_WEAK_NT:   n = went ? CTR_STRONG_T : CTR_STRONG_NT;
         CTR_WEAK_T:    n = went ? CTR_STRONG_T : CTR_STRONG_NT;
         default:       n = went ? CTR_STRONG_T : CTR_WEAK_T;
      endcase
      return n;
   endfunction

endpackage

// ----- design/gbp_req_if.sv -----
// Request channel: one resolved branch per word.
`timescale 1ns / 1ps

interface gbp_req_if;
   logic                        valid;
   logic                        ready;
   logic [gbp_pkg::ADDR_W-1:0]  branch_address;
   logic                        taken;

   modport source (output valid, output branch_address, output taken, input ready);
   modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

// ----- design/gbp_rsp_if.sv -----
// Response channel: prediction, mispredict flag and running totals.
`timescale 1ns / 1ps

interface gbp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        predicted_taken;
   logic                        mispredicted;
   logic [gbp_pkg::COUNT_W-1:0] correct_total;
   logic [gbp_pkg::COUNT_W-1:0] wrong_total;

   modport source (output valid, output predicted_taken, output mispredicted,
                   output correct_total, output wrong_total, input ready);
   modport sink   (input valid, input predicted_taken, input mispredicted,
                   input correct_total, input wrong_total, output ready);
endinterface

// ----- design/gbp_csr_if.sv -----
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface gbp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [gbp_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [gbp_pkg::CSR_DATA_W-1:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ----- design/gbp_pattern_table.sv -----
// Pattern table of two-bit counters with a clearing sweep after reset.
`timescale 1ns / 1ps

module gbp_pattern_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [gbp_pkg::HIST_BITS-1:0]  rd_addr,
   output logic [gbp_pkg::CTR_W-1:0]      rd_data,
   input  gbp_pkg::tbl_write_type         wr,
   output logic                           clearing
);

   logic [gbp_pkg::CTR_W-1:0]     mem [gbp_pkg::TABLE_DEPTH];
   logic [gbp_pkg::CTR_W-1:0]     rd_data_ff;
   logic                          clr_active_ff, clr_active_in;
   logic [gbp_pkg::HIST_BITS-1:0] clr_addr_ff, clr_addr_in;
   gbp_pkg::tbl_write_type        port_wr;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // Sweep zeros through the table until the last entry is written.
   always_comb begin
      if (clr_active_ff) begin
         port_wr.en   = 1'b1;
         port_wr.addr = clr_addr_ff;
         port_wr.data = gbp_pkg::CTR_STRONG_NT;
      end else begin
         port_wr = wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (port_wr.en) begin
         mem[port_wr.addr] <= port_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_active_ff;

endmodule

// ----- design/gbp_front.sv -----
// Configuration registers, global history and table index hashing.
`timescale 1ns / 1ps

module gbp_front (
   input  logic                           clock,
   input  logic                           reset,
   gbp_csr_if.sink                        csr_port,
   input  logic                           accept,
   input  logic [gbp_pkg::ADDR_W-1:0]     branch_address,
   input  logic                           taken,
   output logic [gbp_pkg::HIST_BITS-1:0]  index
);

   logic [gbp_pkg::K_W-1:0]       k_ff, k_in;
   logic                          hash_ff, hash_in;
   logic [gbp_pkg::HIST_BITS-1:0] hist_ff, hist_in;
   logic [gbp_pkg::HIST_BITS-1:0] mask;

   assign csr_port.ready = 1'b1;

   always_comb begin
      k_in    = k_ff;
      hash_in = hash_ff;
      if (csr_port.valid) begin
         case (csr_port.reg_index)
            gbp_pkg::CSR_HISTORY_BITS: k_in    = csr_port.write_data[gbp_pkg::K_W-1:0];
            gbp_pkg::CSR_HASH_ADDRESS: hash_in = csr_port.write_data[0];
            default: ;
         endcase
      end
   end

   // Shift the outcome in at accept; the index uses the history from before.
   assign hist_in = accept ? {hist_ff[gbp_pkg::HIST_BITS-2:0], taken} : hist_ff;

   assign mask  = gbp_pkg::index_mask(k_ff);
   assign index = (hist_ff & mask)
                ^ (hash_ff ? (branch_address[gbp_pkg::HIST_BITS-1:0] & mask) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= gbp_pkg::K_RESET;
         hash_ff <= gbp_pkg::HASH_RESET;
         hist_ff <= '0;
      end else begin
         k_ff    <= k_in;
         hash_ff <= hash_in;
         hist_ff <= hist_in;
      end
   end

endmodule

// ----- design/gbp_update_stage.sv -----
// Predict-and-train stage, running totals and the response register.
`timescale 1ns / 1ps

module gbp_update_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [gbp_pkg::HIST_BITS-1:0]  load_index,
   input  logic                           load_taken,
   input  logic [gbp_pkg::CTR_W-1:0]      rd_data,
   output gbp_pkg::tbl_write_type         tbl_wr,
   output gbp_pkg::stage_status_type      status,
   gbp_rsp_if.source                      rsp_port
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [gbp_pkg::HIST_BITS-1:0] s1_idx_ff;
   logic                          s1_taken_ff;
   logic                          byp_valid_ff;
   logic [gbp_pkg::HIST_BITS-1:0] byp_idx_ff;
   logic [gbp_pkg::CTR_W-1:0]     byp_ctr_ff;
   logic [gbp_pkg::COUNT_W-1:0]   correct_ff, correct_in;
   logic [gbp_pkg::COUNT_W-1:0]   wrong_ff, wrong_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          out_pred_ff;
   logic                          out_mis_ff;
   logic [gbp_pkg::COUNT_W-1:0]   out_correct_ff;
   logic [gbp_pkg::COUNT_W-1:0]   out_wrong_ff;

   logic                          advance;
   logic [gbp_pkg::CTR_W-1:0]     ctr;
   logic [gbp_pkg::CTR_W-1:0]     ctr_new;
   logic                          guess;
   logic                          mis;

   assign advance = s1_valid_ff && (!out_valid_ff || rsp_port.ready);

   // The table read at the edge of the previous write returns stale data: forward it.
   assign ctr     = (byp_valid_ff && (byp_idx_ff == s1_idx_ff)) ? byp_ctr_ff : rd_data;
   assign guess   = ctr[1];
   assign mis     = guess != s1_taken_ff;
   assign ctr_new = gbp_pkg::train(ctr, s1_taken_ff);

   always_comb begin
      correct_in = correct_ff;
      wrong_in   = wrong_ff;
      if (mis) begin
         if (wrong_ff != '1) begin
            wrong_in = wrong_ff + 1'b1;
         end
      end else begin
         if (correct_ff != '1) begin
            correct_in = correct_ff + 1'b1;
         end
      end
   end

   assign s1_valid_in  = load || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_port.ready);

   assign tbl_wr.en   = advance;
   assign tbl_wr.addr = s1_idx_ff;
   assign tbl_wr.data = ctr_new;

   assign status.s1_valid = s1_valid_ff;
   assign status.s1_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         correct_ff   <= '0;
         wrong_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (load) begin
            byp_valid_ff <= advance;
         end
         if (advance) begin
            correct_ff <= correct_in;
            wrong_ff   <= wrong_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_idx_ff   <= load_index;
         s1_taken_ff <= load_taken;
         byp_idx_ff  <= s1_idx_ff;
         byp_ctr_ff  <= ctr_new;
      end
      if (advance) begin
         out_pred_ff    <= guess;
         out_mis_ff     <= mis;
         out_correct_ff <= correct_in;
         out_wrong_ff   <= wrong_in;
      end
   end

   assign rsp_port.valid           = out_valid_ff;
   assign rsp_port.predicted_taken = out_pred_ff;
   assign rsp_port.mispredicted    = out_mis_ff;
   assign rsp_port.correct_total   = out_correct_ff;
   assign rsp_port.wrong_total     = out_wrong_ff;

endmodule

// ----- design/gshare_branch_predictor_unit.sv -----
// Top level of the gshare / GAg branch predictor.
//
//   channel   dir   word
//   req_port  in    branch_address[31:0], taken
//   rsp_port  out   predicted_taken, mispredicted, correct_total[31:0], wrong_total[31:0]
//   csr_port  in    reg_index[3:0], write_data[3:0] (0: history_bits, 1: hash_address)
//
// One word per cycle sustained while rsp_port is ready and the table is not clearing; the
// table read and the request load into the train stage together, the train stage fills rsp_port.
// After reset the table is swept to zero, all 4096 entries, with req_port.ready low;
// csr_port is always ready.
// A stall on rsp_port holds one word in the train stage and one in the response register,
// then drops req_port.ready.
`timescale 1ns / 1ps

module gshare_branch_predictor_unit (
   input  logic       clock,
   input  logic       reset,
   gbp_req_if.sink    req_port,
   gbp_rsp_if.source  rsp_port,
   gbp_csr_if.sink    csr_port
);

   logic                          accept;
   logic                          clearing;
   logic [gbp_pkg::HIST_BITS-1:0] index;
   logic [gbp_pkg::CTR_W-1:0]     rd_data;
   gbp_pkg::tbl_write_type        tbl_wr;
   gbp_pkg::stage_status_type     status;

   assign req_port.ready = !clearing && status.s1_ready;
   assign accept         = req_port.valid && req_port.ready;

   gbp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_port       (csr_port),
      .accept         (accept),
      .branch_address (req_port.branch_address),
      .taken          (req_port.taken),
      .index          (index)
   );

   gbp_pattern_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (index),
      .rd_data  (rd_data),
      .wr       (tbl_wr),
      .clearing (clearing)
   );

   gbp_update_stage u_update (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_index (index),
      .load_taken (req_port.taken),
      .rd_data    (rd_data),
      .tbl_wr     (tbl_wr),
      .status     (status),
      .rsp_port   (rsp_port)
   );

`ifndef SYNTHESIS
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_port.ready)
      else $error("request taken during table clear");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> status.s1_valid)
      else $error("accepted word lost before train stage");

   a_no_write_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !tbl_wr.en)
      else $error("train write during table clear");

   a_wrong_total_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.mispredicted) |-> (rsp_port.wrong_total != '0))
      else $error("mispredict reported with zero wrong total");

   a_correct_total_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.mispredicted) |-> (rsp_port.correct_total != '0))
      else $error("correct prediction reported with zero correct total");
`endif

endmodule

// ----- tb/sv/gshare_branch_predictor_unit_test.sv -----
// Self-checking testbench for the gshare / GAg branch predictor: directed table, random phases.
`timescale 1ns / 1ps

module gshare_branch_predictor_unit_test;

   localparam int RANDOM_ITEMS = 2000;
   localparam int QUIET_TAIL   = 300;
   localparam int SITES        = 8;
   localparam int SETTLE       = 3;

   localparam logic [gbp_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 4'd7;

   typedef enum logic {ROW_BRANCH, ROW_WRITE} row_kind_type;

   typedef struct packed {
      logic                        predicted_taken;
      logic                        mispredicted;
      logic [gbp_pkg::COUNT_W-1:0] correct_total;
      logic [gbp_pkg::COUNT_W-1:0] wrong_total;
   } verdict_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [gbp_pkg::ADDR_W-1:0]     pc;
      logic                           went;
      logic [gbp_pkg::CSR_IDX_W-1:0]  reg_index;
      logic [gbp_pkg::CSR_DATA_W-1:0] reg_data;
      logic                           has_lit;
      verdict_type                    lit;
   } stim_row_type;

   localparam verdict_type NO_LIT = '0;

   // Extremes of address and outcome, counter transitions on one shared counter at zero width,
   // index width clamp, ignored register index, width changes.
   localparam stim_row_type DIRECTED [25] = '{
      '{ROW_BRANCH, 32'h0000_0000, 1'b0, 4'd0, 4'd0, 1'b1, '{1'b0, 1'b0, 32'd1, 32'd0}},
      '{ROW_BRANCH, 32'hFFFF_FFFF, 1'b1, 4'd0, 4'd0, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd1}},
      '{ROW_BRANCH, 32'h5555_5555, 1'b1, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'hAAAA_AAAA, 1'b0, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_WRITE,  32'h0000_0000, 1'b0, gbp_pkg::CSR_HASH_ADDRESS, 4'h0, 1'b0, NO_LIT},
      '{ROW_WRITE,  32'h0000_0000, 1'b0, gbp_pkg::CSR_HISTORY_BITS, 4'd0, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'h1234_5678, 1'b1, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'hEDCB_A987, 1'b1, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'h0000_0000, 1'b0, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'hFFFF_FFFF, 1'b0, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'h0F0F_0F0F, 1'b0, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_WRITE,  32'h0000_0000, 1'b0, gbp_pkg::CSR_HISTORY_BITS, 4'd15, 1'b0, NO_LIT},
      '{ROW_WRITE,  32'h0000_0000, 1'b0, gbp_pkg::CSR_HASH_ADDRESS, 4'hF, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'hFFFF_FFFF, 1'b1, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'h8000_0000, 1'b1, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'h0000_0FFF, 1'b0, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_WRITE,  32'h0000_0000, 1'b0, CSR_SPARE_INDEX, 4'h3, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'hFFFF_FFFF, 1'b1, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_WRITE,  32'h0000_0000, 1'b0, gbp_pkg::CSR_HISTORY_BITS, 4'd12, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'hFFFF_F000, 1'b1, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'h0000_0001, 1'b0, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_WRITE,  32'h0000_0000, 1'b0, gbp_pkg::CSR_HISTORY_BITS, 4'd1, 1'b0, NO_LIT},
      '{ROW_WRITE,  32'h0000_0000, 1'b0, gbp_pkg::CSR_HASH_ADDRESS, 4'hE, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'hFFFF_FFFF, 1'b1, 4'd0, 4'd0, 1'b0, NO_LIT},
      '{ROW_BRANCH, 32'h0000_0000, 1'b0, 4'd0, 4'd0, 1'b0, NO_LIT}
   };

   logic clock;
   logic reset;

   gbp_req_if req_if ();
   gbp_rsp_if rsp_if ();
   gbp_csr_if csr_if ();

   gshare_branch_predictor_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // predictor state
   logic [gbp_pkg::K_W-1:0]       model_k;
   logic                          model_hash;
   logic [gbp_pkg::HIST_BITS-1:0] model_hist;
   logic [gbp_pkg::CTR_W-1:0]     pattern_ctr [gbp_pkg::TABLE_DEPTH];
   logic [gbp_pkg::COUNT_W-1:0]   hits_total;
   logic [gbp_pkg::COUNT_W-1:0]   misses_total;

   verdict_type verdict_q [$];
   int          mismatch_count;

   // tags riding with each request word
   logic        req_lit_on;
   verdict_type req_lit;

   int src_idle_pct;
   int sink_idle_pct;
   int sink_stall_left;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("FAIL gshare_branch_predictor_unit");
      $finish;
   end

   // Predict one branch and update the totals, then train the counter and shift the history.
   function automatic verdict_type resolve_branch(input logic [gbp_pkg::ADDR_W-1:0] pc,
                                                  input logic went);
      logic [gbp_pkg::HIST_BITS-1:0] mask;
      logic [gbp_pkg::HIST_BITS-1:0] slot;
      logic [gbp_pkg::CTR_W-1:0]     ctr;
      int                            width;
      verdict_type                   v;
      width = (int'(model_k) > gbp_pkg::HIST_BITS) ? gbp_pkg::HIST_BITS : int'(model_k);
      mask = (gbp_pkg::HIST_BITS'(1) << width) - gbp_pkg::HIST_BITS'(1);
      slot = model_hist & mask;
      if (model_hash) slot = slot ^ (pc[gbp_pkg::HIST_BITS-1:0] & mask);
      ctr = pattern_ctr[slot];
      v.predicted_taken = ctr[1];
      v.mispredicted = (ctr[1] != went);
      if (v.mispredicted) begin
         if (misses_total != '1) misses_total = misses_total + 1'b1;
      end else begin
         if (hits_total != '1) hits_total = hits_total + 1'b1;
      end
      v.correct_total = hits_total;
      v.wrong_total = misses_total;
      if (went) begin
         if (ctr == gbp_pkg::CTR_WEAK_NT || ctr == gbp_pkg::CTR_STRONG_T)
            pattern_ctr[slot] = gbp_pkg::CTR_STRONG_T;
         else pattern_ctr[slot] = ctr + 2'd1;
      end else begin
         if (ctr == gbp_pkg::CTR_WEAK_T || ctr == gbp_pkg::CTR_STRONG_NT)
            pattern_ctr[slot] = gbp_pkg::CTR_STRONG_NT;
         else pattern_ctr[slot] = ctr - 2'd1;
      end
      model_hist = {model_hist[gbp_pkg::HIST_BITS-2:0], went};
      return v;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.reg_index)
               gbp_pkg::CSR_HISTORY_BITS: model_k = csr_if.write_data;
               gbp_pkg::CSR_HASH_ADDRESS: model_hash = csr_if.write_data[0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            want = resolve_branch(req_if.branch_address, req_if.taken);
            if (req_lit_on) want = req_lit;
            verdict_q.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.predicted_taken, rsp_if.mispredicted,
                    rsp_if.correct_total, rsp_if.wrong_total};
            if (verdict_q.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, got %0h", $time, got);
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               check_field("predicted_taken", 32'(want.predicted_taken),
                           32'(got.predicted_taken));
               check_field("mispredicted", 32'(want.mispredicted), 32'(got.mispredicted));
               check_field("correct_total", want.correct_total, got.correct_total);
               check_field("wrong_total", want.wrong_total, got.wrong_total);
            end
         end
      end
   end

   // Result side back-pressure in bursts.
   always @(posedge clock) begin
      if (sink_stall_left != 0) begin
         sink_stall_left <= sink_stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
         sink_stall_left <= $urandom_range(1, 17) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send_branch(input logic [gbp_pkg::ADDR_W-1:0] pc, input logic went,
                              input logic lit_on, input verdict_type lit);
      req_if.branch_address <= pc;
      req_if.taken <= went;
      req_lit_on <= lit_on;
      req_lit <= lit;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic hold_off(input int cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending and wait until every expected word has come back.
   task automatic await_drain();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (verdict_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [gbp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gbp_pkg::CSR_DATA_W-1:0] data);
      csr_if.reg_index <= idx;
      csr_if.write_data <= data;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [gbp_pkg::ADDR_W-1:0] site_pc     [SITES];
      int                         site_period [SITES];
      logic                       site_flip   [SITES];
      int                         site_step   [SITES];
      logic [gbp_pkg::ADDR_W-1:0] pc;
      logic                       went;
      logic [gbp_pkg::K_W-1:0]    k;
      int                         rand_sent;
      int                         phase_len;
      int                         s;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.branch_address = '0;
      req_if.taken = 1'b0;
      req_lit_on = 1'b0;
      req_lit = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.reg_index = '0;
      csr_if.write_data = '0;
      src_idle_pct = 20;
      sink_idle_pct = 20;
      sink_stall_left = 0;
      mismatch_count = 0;
      model_k = gbp_pkg::K_RESET;
      model_hash = gbp_pkg::HASH_RESET;
      model_hist = '0;
      hits_total = '0;
      misses_total = '0;
      foreach (pattern_ctr[i]) pattern_ctr[i] = gbp_pkg::CTR_STRONG_NT;
      foreach (site_step[i]) site_step[i] = 0;
      rand_sent = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_WRITE) begin
            await_drain();
            write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_data);
         end else begin
            if ($urandom_range(0, 99) < src_idle_pct) hold_off($urandom_range(1, 17));
            send_branch(DIRECTED[i].pc, DIRECTED[i].went, DIRECTED[i].has_lit, DIRECTED[i].lit);
         end
      end

      while (rand_sent < RANDOM_ITEMS) begin
         await_drain();
         if (rand_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
            src_idle_pct = 0;
            sink_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: src_idle_pct = 0;
               1: src_idle_pct = 10;
               default: src_idle_pct = 30;
            endcase
            case ($urandom_range(0, 2))
               0: sink_idle_pct = 0;
               1: sink_idle_pct = 10;
               default: sink_idle_pct = 30;
            endcase
         end

         // favor the width extremes now and then
         case ($urandom_range(0, 9))
            6: k = 4'd0;
            7: k = 4'd1;
            8: k = 4'd12;
            9: k = 4'($urandom_range(13, 15));
            default: k = 4'($urandom_range(2, 11));
         endcase
         write_reg(gbp_pkg::CSR_HISTORY_BITS, k);
         write_reg(gbp_pkg::CSR_HASH_ADDRESS, 4'($urandom_range(0, 15)));
         if ($urandom_range(0, 99) < 30)
            write_reg(4'($urandom_range(int'(gbp_pkg::CSR_HASH_ADDRESS) + 1, 15)),
                      4'($urandom_range(0, 15)));

         // new branch sites with loop-like outcome patterns
         for (int i = 0; i < SITES; i++) begin
            site_pc[i] = $urandom();
            site_period[i] = $urandom_range(1, 6);
            site_flip[i] = 1'($urandom_range(0, 1));
         end

         phase_len = $urandom_range(100, 250);
         repeat (phase_len) begin
            if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
               hold_off($urandom_range(1, 17));
            if ($urandom_range(0, 99) < 20) begin
               pc = $urandom();
               went = 1'($urandom_range(0, 1));
            end else begin
               s = $urandom_range(0, SITES - 1);
               pc = site_pc[s];
               went = ((site_step[s] % site_period[s]) != 0) ^ site_flip[s];
               if ($urandom_range(0, 99) < 4) went = !went;
               site_step[s]++;
            end
            send_branch(pc, went, 1'b0, NO_LIT);
            rand_sent++;
         end
      end

      await_drain();
      repeat (8) @(posedge clock);
      if (verdict_q.size() != 0) begin
         $display("%0t ns: missing results, expected 0 outstanding, got %0d",
                  $time, verdict_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("PASS gshare_branch_predictor_unit");
      end else begin
         $display("FAIL gshare_branch_predictor_unit");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/gbp_pkg.sv
design/gbp_req_if.sv
design/gbp_rsp_if.sv
design/gbp_csr_if.sv
design/gbp_pattern_table.sv
design/gbp_front.sv
design/gbp_update_stage.sv
design/gshare_branch_predictor_unit.sv
tb/sv/gshare_branch_predictor_unit_test.sv
